// File: hw/rtl/heightmap_mesh_flat_normals_core_assert.svh
// Assertion macros used by the checker file.
`ifndef HEIGHTMAP_MESH_FLAT_NORMALS_CORE_ASSERT_SVH
`define HEIGHTMAP_MESH_FLAT_NORMALS_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define HMFN_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define HMFN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/hmfn_pkg.sv
`default_nettype none
package hmfn_pkg;

  localparam int unsigned MAX_GRID_DEF = 1024;
  localparam int unsigned GRID_RESET   = 64;
  localparam int unsigned HEIGHT_W     = 16;
  localparam int unsigned DIFF_W       = HEIGHT_W + 1;
  localparam int unsigned CFG_W        = 11;
  localparam int unsigned COORD_W      = 16;
  localparam int unsigned NORM_W       = 16;
  localparam int unsigned NORM_ONE     = 16384;
  localparam int unsigned MAG_W        = 24;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned ADDR_W       = 3;

  // register index, taken from paddr above the byte offset
  localparam logic REG_GRID_SIZE = 1'b0;

  typedef struct packed {
    logic signed [NORM_W-1:0] x;
    logic signed [NORM_W-1:0] y;
    logic signed [NORM_W-1:0] z;
  } norm_t;

endpackage
`default_nettype wire

// File: hw/rtl/hmfn_if.sv
`default_nettype none
interface hmfn_in_if;
  import hmfn_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [HEIGHT_W-1:0] height;
  modport source (output valid, output height, input ready);
  modport sink   (input valid, input height, output ready);
endinterface

interface hmfn_out_if;
  import hmfn_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [COORD_W-1:0]         pos_x;
  logic [COORD_W-1:0]         pos_y;
  logic signed [HEIGHT_W-1:0] pos_z;
  logic signed [NORM_W-1:0]   norm_x;
  logic signed [NORM_W-1:0]   norm_y;
  logic signed [NORM_W-1:0]   norm_z;
  logic                       last;
  modport source (output valid, output pos_x, output pos_y, output pos_z, output norm_x,
                  output norm_y, output norm_z, output last, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input pos_z, input norm_x,
                  input norm_y, input norm_z, input last, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/hmfn_ram.sv
`default_nettype none
module hmfn_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: hw/rtl/hmfn_posdiv.sv
`default_nettype none
module hmfn_posdiv #(
  parameter int unsigned IW = 10,
  parameter int unsigned NW = 11
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  input  wire logic [3:0][IW-1:0]              x,
  input  wire logic [NW-1:0]                   n,
  output logic                                 busy,
  output logic [3:0][hmfn_pkg::COORD_W-1:0]    q
);
  import hmfn_pkg::*;

  localparam int unsigned CNT_W = $clog2(COORD_W);

  logic [3:0][NW-1:0]      rem_r;
  logic [3:0][COORD_W-1:0] q_r;
  logic [CNT_W-1:0]        cnt_r;
  logic                    busy_r;
  logic [3:0][NW:0]        rem2;
  logic [3:0]              ge;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      rem2[l] = {rem_r[l], 1'b0};
      ge[l]   = rem2[l] >= {1'b0, n};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
      for (int l = 0; l < 4; l++) begin
        rem_r[l] <= NW'(x[l]);
        q_r[l]   <= '0;
      end
    end else if (busy_r) begin
      // one quotient bit per lane and cycle
      for (int l = 0; l < 4; l++) begin
        rem_r[l] <= ge[l] ? NW'(rem2[l] - {1'b0, n}) : NW'(rem2[l]);
        q_r[l]   <= {q_r[l][COORD_W-2:0], ge[l]};
      end
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CNT_W'(COORD_W - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy = busy_r;
  assign q    = q_r;
endmodule
`default_nettype wire

// File: hw/rtl/hmfn_normal.sv
`default_nettype none
module hmfn_normal #(
  parameter int unsigned NW = 11
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  input  wire logic signed [hmfn_pkg::DIFF_W-1:0] d0,
  input  wire logic signed [hmfn_pkg::DIFF_W-1:0] d1,
  input  wire logic [NW-1:0]                      n,
  output logic                                    done,
  output hmfn_pkg::norm_t                         norm
);
  import hmfn_pkg::*;

  localparam int unsigned PW   = DIFF_W + NW + 1;
  localparam int unsigned MW   = PW - 1;
  localparam int unsigned KMAX = (MW > MAG_W) ? MW - MAG_W : 0;
  localparam int unsigned KSW  = $clog2(KMAX + 2);
  localparam int unsigned SQ_W = 2 * MAG_W;
  localparam int unsigned LEN_W = SQ_W + 2;
  localparam int unsigned ROOT_STEPS = 32;

  localparam logic [2:0] NS_IDLE  = 3'd0;
  localparam logic [2:0] NS_MUL   = 3'd1;
  localparam logic [2:0] NS_SHIFT = 3'd2;
  localparam logic [2:0] NS_SQ    = 3'd3;
  localparam logic [2:0] NS_ROOT  = 3'd4;
  localparam logic [2:0] NS_TSET  = 3'd5;
  localparam logic [2:0] NS_DINIT = 3'd6;
  localparam logic [2:0] NS_DIV   = 3'd7;

  logic [2:0]               st_r;
  logic signed [DIFF_W-1:0] d0_r, d1_r;
  logic [NW-1:0]            n_r;
  logic signed [PW-1:0]     c0_r, c1_r;
  logic [MAG_W-1:0]         mag_r [3];
  logic [1:0]               neg_r;
  logic [SQ_W-1:0]          sq_r;
  logic [LEN_W-1:0]         len_r;
  logic [4:0]               cnt_r;
  logic [63:0]              v_r, r_r, bit_r;
  logic [31:0]              t_r;
  logic [1:0]               comp_r;
  logic [47:0]              rem_r, dsh_r;
  logic [NORM_W-1:0]        q_r;
  logic signed [NORM_W-1:0] res_r [3];
  logic                     done_r;

  logic [MW-1:0]     ma0, ma1, m;
  logic [KSW-1:0]    ksel;
  logic [63:0]       rb;
  logic              ge;
  logic [NORM_W-1:0] qn, qc;
  logic              neg_c;

  always_comb begin
    ma0 = c0_r[PW-1] ? MW'(-c0_r) : MW'(c0_r);
    ma1 = c1_r[PW-1] ? MW'(-c1_r) : MW'(c1_r);
    m   = MW'(NORM_ONE);
    if (ma0 > m) m = ma0;
    if (ma1 > m) m = ma1;
    // least shift that brings the largest magnitude below 2^24
    ksel = '0;
    for (int kk = KMAX; kk >= 0; kk--) begin
      if ((64'(m) >> kk) < (64'd1 << MAG_W)) ksel = KSW'(kk);
    end
    rb    = r_r + bit_r;
    ge    = rem_r >= dsh_r;
    qn    = {q_r[NORM_W-2:0], ge};
    qc    = (qn > NORM_W'(NORM_ONE)) ? NORM_W'(NORM_ONE) : qn;
    neg_c = (comp_r == 2'd2) ? 1'b0 : neg_r[comp_r[0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= NS_IDLE;
      done_r <= 1'b0;
      cnt_r  <= '0;
      comp_r <= '0;
    end else begin
      done_r <= (st_r == NS_DIV) && (cnt_r == 5'(NORM_W - 1)) && (comp_r == 2'd2);
      case (st_r)
        NS_IDLE: begin
          if (start) begin
            d0_r <= d0;
            d1_r <= d1;
            n_r  <= n;
            st_r <= NS_MUL;
          end
        end
        NS_MUL: begin
          c0_r <= d0_r * $signed({1'b0, n_r});
          c1_r <= d1_r * $signed({1'b0, n_r});
          st_r <= NS_SHIFT;
        end
        NS_SHIFT: begin
          mag_r[0] <= MAG_W'(ma0 >> ksel);
          mag_r[1] <= MAG_W'(ma1 >> ksel);
          mag_r[2] <= MAG_W'(NORM_ONE) >> ksel;
          neg_r    <= {c1_r[PW-1], c0_r[PW-1]};
          len_r    <= '0;
          cnt_r    <= '0;
          st_r     <= NS_SQ;
        end
        NS_SQ: begin
          // square one component, accumulate the previous square
          if (cnt_r < 5'd3) begin
            sq_r <= mag_r[cnt_r[1:0]] * mag_r[cnt_r[1:0]];
          end
          if (cnt_r != 5'd0) begin
            len_r <= len_r + LEN_W'(sq_r);
          end
          if (cnt_r == 5'd3) begin
            v_r   <= {LEN_W'(len_r + LEN_W'(sq_r)), 12'b0};
            r_r   <= '0;
            bit_r <= 64'd1 << 62;
            cnt_r <= '0;
            st_r  <= NS_ROOT;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        NS_ROOT: begin
          if (v_r >= rb) begin
            v_r <= v_r - rb;
            r_r <= (r_r >> 1) + bit_r;
          end else begin
            r_r <= r_r >> 1;
          end
          bit_r <= bit_r >> 2;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 5'(ROOT_STEPS - 1)) begin
            st_r <= NS_TSET;
          end
        end
        NS_TSET: begin
          t_r    <= (r_r == 64'd0) ? 32'd1 : r_r[31:0];
          comp_r <= '0;
          st_r   <= NS_DINIT;
        end
        NS_DINIT: begin
          rem_r <= 48'({mag_r[comp_r], 21'b0}) + 48'(t_r);
          dsh_r <= {t_r, 16'b0};
          q_r   <= '0;
          cnt_r <= '0;
          st_r  <= NS_DIV;
        end
        NS_DIV: begin
          if (ge) begin
            rem_r <= rem_r - dsh_r;
          end
          q_r   <= qn;
          dsh_r <= dsh_r >> 1;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 5'(NORM_W - 1)) begin
            res_r[comp_r] <= neg_c ? -$signed(qc) : $signed(qc);
            if (comp_r == 2'd2) begin
              st_r <= NS_IDLE;
            end else begin
              comp_r <= comp_r + 1'b1;
              st_r   <= NS_DINIT;
            end
          end
        end
        default: st_r <= NS_IDLE;
      endcase
    end
  end

  assign done   = done_r;
  assign norm.x = res_r[0];
  assign norm.y = res_r[1];
  assign norm.z = res_r[2];
endmodule
`default_nettype wire

// File: hw/rtl/heightmap_mesh_flat_normals_core.sv
`default_nettype none
// Heightmap mesher: height samples of an N x N grid come in row-major order, one beat
// each; every sample past the first row and column closes a quad and yields six vertex
// beats (two triangles, each with its flat unit normal), other samples yield none. The
// previous row lives in a line RAM of MAX_GRID entries read and written once per sample.
// A closing sample runs the shared normal unit twice, each run doing the square-root
// iterations and three 16-step divides, and then hands out the six vertices; each
// stalled vertex beat adds its stall cycles.
// grid_size (register 0, low 11 bits) restarts the grid when written; values are clamped to
// 2..MAX_GRID. Write it only while the block is idle.
module heightmap_mesh_flat_normals_core #(
  parameter int unsigned MAX_GRID = hmfn_pkg::MAX_GRID_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  hmfn_in_if.sink                            in_ch,
  hmfn_out_if.source                         out_ch,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [hmfn_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [hmfn_pkg::DATA_W-1:0]   pwdata,
  output logic      [hmfn_pkg::DATA_W-1:0]   prdata,
  output logic                               pready
);
  import hmfn_pkg::*;

  localparam int unsigned IW = (MAX_GRID > 1) ? $clog2(MAX_GRID) : 1;
  localparam int unsigned NW = $clog2(MAX_GRID + 1);
  localparam int unsigned GRID_INIT = (GRID_RESET > MAX_GRID) ? MAX_GRID : GRID_RESET;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_GO   = 3'd2;
  localparam logic [2:0] ST_N1   = 3'd3;
  localparam logic [2:0] ST_N2   = 3'd4;
  localparam logic [2:0] ST_EMIT = 3'd5;

  localparam logic [2:0] VTX_0 = 3'd0;
  localparam logic [2:0] VTX_1 = 3'd1;
  localparam logic [2:0] VTX_2 = 3'd2;
  localparam logic [2:0] VTX_3 = 3'd3;
  localparam logic [2:0] VTX_4 = 3'd4;
  localparam logic [2:0] VTX_5 = 3'd5;

  logic [2:0]                 st_r;
  logic [NW-1:0]              grid_r;
  logic [IW-1:0]              row_r, col_r, item_row_r, item_col_r;
  logic [HEIGHT_W-1:0]        h_r, h0_r, h1_r, h2_r, prev_sample_r, prev_left_r;
  norm_t                      n1_r, n2_r;
  logic [2:0]                 vcnt_r;
  logic                       ov_r, olast_r;
  logic [COORD_W-1:0]         ox_r, oy_r;
  logic [HEIGHT_W-1:0]        oz_r;
  norm_t                      on_r;

  logic                       in_acc, cfg_wr, closes;
  logic [CFG_W-1:0]           cfg_v;
  logic [NW-1:0]              grid_nxt;
  logic [HEIGHT_W-1:0]        above;
  logic                       nrm_start, nrm_done;
  logic signed [DIFF_W-1:0]   nd0, nd1;
  norm_t                      nrm;
  logic                       pd_busy;
  logic [3:0][IW-1:0]         pd_x;
  logic [3:0][COORD_W-1:0]    pd_q;
  logic                       load;
  logic                       sel_x, sel_y, sel_n;
  logic [HEIGHT_W-1:0]        sel_z;

  function automatic logic signed [DIFF_W-1:0] hdiff(logic [HEIGHT_W-1:0] a,
                                                     logic [HEIGHT_W-1:0] b);
    return $signed({a[HEIGHT_W-1], a}) - $signed({b[HEIGHT_W-1], b});
  endfunction

  hmfn_ram #(.WIDTH(HEIGHT_W), .DEPTH(MAX_GRID), .AW(IW)) u_line (
    .clk   (clk),
    .we    (st_r == ST_RD),
    .waddr (item_col_r),
    .wdata (h_r),
    .raddr (col_r),
    .rdata (above)
  );

  assign nrm_start = (st_r == ST_GO) || ((st_r == ST_N1) && nrm_done);
  assign nd0 = (st_r == ST_GO) ? hdiff(h0_r, h2_r) : hdiff(h1_r, h_r);
  assign nd1 = (st_r == ST_GO) ? hdiff(h0_r, h1_r) : hdiff(h2_r, h_r);

  hmfn_normal #(.NW(NW)) u_normal (
    .clk   (clk),
    .rst_n (rst_n),
    .start (nrm_start),
    .d0    (nd0),
    .d1    (nd1),
    .n     (grid_r),
    .done  (nrm_done),
    .norm  (nrm)
  );

  assign pd_x[0] = item_row_r - 1'b1;
  assign pd_x[1] = item_row_r;
  assign pd_x[2] = item_col_r - 1'b1;
  assign pd_x[3] = item_col_r;

  hmfn_posdiv #(.IW(IW), .NW(NW)) u_posdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (st_r == ST_GO),
    .x     (pd_x),
    .n     (grid_r),
    .busy  (pd_busy),
    .q     (pd_q)
  );

  assign in_acc = in_ch.valid && in_ch.ready;
  assign cfg_wr = psel && penable && pwrite && (paddr[ADDR_W-1] == REG_GRID_SIZE);
  assign cfg_v  = pwdata[CFG_W-1:0];
  assign closes = (item_row_r != '0) && (item_col_r != '0);
  assign load   = (st_r == ST_EMIT) && !pd_busy && (!ov_r || out_ch.ready);

  always_comb begin
    if (cfg_v < CFG_W'(2)) begin
      grid_nxt = NW'(2);
    end else if (32'(cfg_v) > 32'(MAX_GRID)) begin
      grid_nxt = NW'(MAX_GRID);
    end else begin
      grid_nxt = NW'(cfg_v);
    end
  end

  // vertex order: v0 v2 v1 with n1, then v2 v3 v1 with n2
  always_comb begin
    case (vcnt_r)
      VTX_0:   begin sel_x = 1'b0; sel_y = 1'b0; sel_z = h0_r; sel_n = 1'b0; end
      VTX_1:   begin sel_x = 1'b1; sel_y = 1'b0; sel_z = h2_r; sel_n = 1'b0; end
      VTX_2:   begin sel_x = 1'b0; sel_y = 1'b1; sel_z = h1_r; sel_n = 1'b0; end
      VTX_3:   begin sel_x = 1'b1; sel_y = 1'b0; sel_z = h2_r; sel_n = 1'b1; end
      VTX_4:   begin sel_x = 1'b1; sel_y = 1'b1; sel_z = h_r;  sel_n = 1'b1; end
      VTX_5:   begin sel_x = 1'b0; sel_y = 1'b1; sel_z = h1_r; sel_n = 1'b1; end
      default: begin sel_x = 1'b0; sel_y = 1'b0; sel_z = h0_r; sel_n = 1'b0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r          <= ST_IDLE;
      grid_r        <= NW'(GRID_INIT);
      row_r         <= '0;
      col_r         <= '0;
      prev_sample_r <= '0;
      prev_left_r   <= '0;
      vcnt_r        <= '0;
      ov_r          <= 1'b0;
    end else begin
      if (ov_r && out_ch.ready && !load) begin
        ov_r <= 1'b0;
      end
      case (st_r)
        ST_IDLE: begin
          if (in_acc) begin
            h_r        <= in_ch.height;
            item_row_r <= row_r;
            item_col_r <= col_r;
            st_r       <= ST_RD;
          end
        end
        ST_RD: begin
          h0_r          <= prev_left_r;
          h1_r          <= above;
          h2_r          <= prev_sample_r;
          prev_left_r   <= above;
          prev_sample_r <= h_r;
          if (32'(item_col_r) + 32'd1 >= 32'(grid_r)) begin
            col_r <= '0;
            row_r <= (32'(item_row_r) + 32'd1 >= 32'(grid_r)) ? '0 : IW'(item_row_r + 1'b1);
          end else begin
            col_r <= IW'(item_col_r + 1'b1);
          end
          st_r <= closes ? ST_GO : ST_IDLE;
        end
        ST_GO: st_r <= ST_N1;
        ST_N1: begin
          if (nrm_done) begin
            n1_r <= nrm;
            st_r <= ST_N2;
          end
        end
        ST_N2: begin
          if (nrm_done) begin
            n2_r   <= nrm;
            vcnt_r <= VTX_0;
            st_r   <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (load) begin
            ov_r    <= 1'b1;
            ox_r    <= sel_x ? pd_q[1] : pd_q[0];
            oy_r    <= sel_y ? pd_q[3] : pd_q[2];
            oz_r    <= sel_z;
            on_r    <= sel_n ? n2_r : n1_r;
            olast_r <= (vcnt_r == VTX_5);
            vcnt_r  <= vcnt_r + 1'b1;
            if (vcnt_r == VTX_5) begin
              st_r <= ST_IDLE;
            end
          end
        end
        default: st_r <= ST_IDLE;
      endcase
      if (cfg_wr) begin
        grid_r <= grid_nxt;
        row_r  <= '0;
        col_r  <= '0;
      end
    end
  end

  assign in_ch.ready   = (st_r == ST_IDLE);
  assign out_ch.valid  = ov_r;
  assign out_ch.pos_x  = ox_r;
  assign out_ch.pos_y  = oy_r;
  assign out_ch.pos_z  = oz_r;
  assign out_ch.norm_x = on_r.x;
  assign out_ch.norm_y = on_r.y;
  assign out_ch.norm_z = on_r.z;
  assign out_ch.last   = olast_r;
  assign prdata        = DATA_W'(grid_r);
  assign pready        = 1'b1;
endmodule
`default_nettype wire

// File: hw/rtl/hmfn_checker.sv
`default_nettype none
`include "heightmap_mesh_flat_normals_core_assert.svh"
module hmfn_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_last
);
  // a stalled result beat stays up
  `HMFN_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "out beat dropped")
  // one sample at a time: no beat accepted right after another
  `HMFN_ASSERT_NEXT(a_in_gap, in_valid && in_ready, !in_ready, "back-to-back in beats")
  // mid-quad vertices block new samples
  `HMFN_ASSERT_NOW(a_quad_busy, out_valid && !out_last, !in_ready, "in ready mid-quad")
  // the next vertex of a quad follows without a bubble
  `HMFN_ASSERT_NEXT(a_run_tight, out_valid && out_ready && !out_last, out_valid,
                    "gap inside a quad")
endmodule

bind heightmap_mesh_flat_normals_core hmfn_checker u_hmfn_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_last  (out_ch.last)
);
`default_nettype wire

// File: bench/heightmap_mesh_flat_normals_core_tb.sv
`timescale 1ns / 1ps

module heightmap_mesh_flat_normals_core_tb;
  import hmfn_pkg::*;

  localparam logic [ADDR_W-1:0] GRID_SIZE_ADDR = {REG_GRID_SIZE, 2'b00};
  localparam int DRAIN_CYCLES = 400;

  typedef struct {
    logic [COORD_W-1:0]         px;
    logic [COORD_W-1:0]         py;
    logic signed [HEIGHT_W-1:0] pz;
    norm_t                      n;
    logic                       last;
  } vertex_t;

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  hmfn_in_if  in_if();
  hmfn_out_if out_if();

  heightmap_mesh_flat_normals_core DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_if), .out_ch(out_if),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // mesher state mirrored for prediction
  int unsigned                grid_n;
  logic signed [HEIGHT_W-1:0] line_mem [MAX_GRID_DEF];
  logic signed [HEIGHT_W-1:0] left_h;
  logic signed [HEIGHT_W-1:0] above_left_h;
  int unsigned                row_i;
  int unsigned                col_j;

  logic signed [HEIGHT_W-1:0] sample_q [$];
  vertex_t                    vertex_q [$];
  int                         err_cnt;
  bit                         sample_taken;
  int                         burst_left;
  int                         gap_left;
  int                         stall_mode;
  int                         stall_cnt;

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic norm_t flat_normal(input longint cx, input longint cy, input longint cz);
    longint          c [3];
    longint unsigned mag [3];
    longint unsigned m, len, t, q;
    int              k;
    norm_t           res;
    logic signed [NORM_W-1:0] comp [3];
    c[0] = cx; c[1] = cy; c[2] = cz;
    m = 0;
    for (int a = 0; a < 3; a++) begin
      mag[a] = (c[a] < 0) ? -c[a] : c[a];
      if (mag[a] > m) m = mag[a];
    end
    k = 0;
    while (k < 63 && (m >> k) >= (64'd1 << MAG_W)) k++;
    len = 0;
    for (int a = 0; a < 3; a++) begin
      mag[a] = mag[a] >> k;
      len += mag[a] * mag[a];
    end
    t = int_sqrt(len << 12);
    if (t == 0) t = 1;
    for (int a = 0; a < 3; a++) begin
      q = ((mag[a] << 21) + t) / (2 * t);
      if (q > NORM_ONE) q = NORM_ONE;
      comp[a] = (c[a] < 0) ? -q[NORM_W-1:0] : q[NORM_W-1:0];
    end
    res.x = comp[0]; res.y = comp[1]; res.z = comp[2];
    return res;
  endfunction

  function automatic vertex_t make_vertex(input int unsigned r, input int unsigned col,
                                          input logic signed [HEIGHT_W-1:0] h,
                                          input norm_t n, input logic lst);
    vertex_t v;
    longint unsigned sx, sy;
    sx = (longint'(r) << 16) / grid_n;
    sy = (longint'(col) << 16) / grid_n;
    v.px = sx[COORD_W-1:0];
    v.py = sy[COORD_W-1:0];
    v.pz = h;
    v.n = n;
    v.last = lst;
    return v;
  endfunction

  // advance the grid by one sample, queue the quad's six vertices if it closes one
  task automatic mesh_sample(input logic signed [HEIGHT_W-1:0] h);
    logic signed [HEIGHT_W-1:0] h0, h1, h2, h3;
    longint nn, da, db, dc, dd;
    norm_t n1, n2;
    h1 = line_mem[col_j];
    if (row_i >= 1 && col_j >= 1) begin
      h0 = above_left_h; h2 = left_h; h3 = h;
      nn = grid_n;
      da = (longint'(h0) - longint'(h2)) * nn;
      db = (longint'(h1) - longint'(h2)) * nn;
      dc = (longint'(h2) - longint'(h3)) * nn;
      dd = (longint'(h1) - longint'(h3)) * nn;
      n1 = flat_normal(da, da - db, NORM_ONE);
      n2 = flat_normal(dd, dc, NORM_ONE);
      vertex_q = {vertex_q, make_vertex(row_i - 1, col_j - 1, h0, n1, 1'b0)};
      vertex_q = {vertex_q, make_vertex(row_i, col_j - 1, h2, n1, 1'b0)};
      vertex_q = {vertex_q, make_vertex(row_i - 1, col_j, h1, n1, 1'b0)};
      vertex_q = {vertex_q, make_vertex(row_i, col_j - 1, h2, n2, 1'b0)};
      vertex_q = {vertex_q, make_vertex(row_i, col_j, h3, n2, 1'b0)};
      vertex_q = {vertex_q, make_vertex(row_i - 1, col_j, h1, n2, 1'b1)};
    end
    above_left_h = h1;
    line_mem[col_j] = h;
    left_h = h;
    col_j++;
    if (col_j >= grid_n) begin
      col_j = 0;
      row_i++;
      if (row_i >= grid_n) row_i = 0;
    end
  endtask

  // sample side: bursts with random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_if.height <= '0;
    end else if (!(in_if.valid && !sample_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_if.valid <= 1'b0;
      end else if (sample_q.size() > 0) begin
        in_if.valid <= 1'b1;
        in_if.height <= sample_q[0];
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 12);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
        end
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // vertex side: stall pattern drawn at random from four modes
  always @(negedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      stall_cnt++;
      if (stall_cnt % 64 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= $urandom_range(0, 1);
        2: out_if.ready <= (stall_cnt % 4 == 0);
        default: out_if.ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    vertex_t exp_v;
    sample_taken = 1'b0;
    if (rst_n && in_if.valid && in_if.ready) begin
      sample_taken = 1'b1;
      mesh_sample(in_if.height);
      void'(sample_q.pop_front());
    end
    if (rst_n && out_if.valid && out_if.ready) begin
      if (vertex_q.size() == 0) begin
        $display("%0t: unexpected vertex x=%h y=%h z=%h", $time,
                 out_if.pos_x, out_if.pos_y, out_if.pos_z);
        err_cnt++;
      end else begin
        exp_v = vertex_q.pop_front();
        if (out_if.pos_x !== exp_v.px)
          $display("%0t: pos_x exp %h got %h", $time, exp_v.px, out_if.pos_x);
        if (out_if.pos_y !== exp_v.py)
          $display("%0t: pos_y exp %h got %h", $time, exp_v.py, out_if.pos_y);
        if (out_if.pos_z !== exp_v.pz)
          $display("%0t: pos_z exp %h got %h", $time, exp_v.pz, out_if.pos_z);
        if (out_if.norm_x !== exp_v.n.x)
          $display("%0t: norm_x exp %h got %h", $time, exp_v.n.x, out_if.norm_x);
        if (out_if.norm_y !== exp_v.n.y)
          $display("%0t: norm_y exp %h got %h", $time, exp_v.n.y, out_if.norm_y);
        if (out_if.norm_z !== exp_v.n.z)
          $display("%0t: norm_z exp %h got %h", $time, exp_v.n.z, out_if.norm_z);
        if (out_if.last !== exp_v.last)
          $display("%0t: last exp %b got %b", $time, exp_v.last, out_if.last);
        if (out_if.pos_x !== exp_v.px || out_if.pos_y !== exp_v.py ||
            out_if.pos_z !== exp_v.pz || out_if.norm_x !== exp_v.n.x ||
            out_if.norm_y !== exp_v.n.y || out_if.norm_z !== exp_v.n.z ||
            out_if.last !== exp_v.last)
          err_cnt++;
      end
    end
  end

  task automatic wait_idle();
    while (sample_q.size() > 0 || in_if.valid || vertex_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_grid_size(input int unsigned value);
    int unsigned v;
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= GRID_SIZE_ADDR; pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    v = value & 32'h7FF;
    if (v < 2) v = 2;
    if (v > MAX_GRID_DEF) v = MAX_GRID_DEF;
    grid_n = v;
    row_i = 0;
    col_j = 0;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  function automatic logic signed [HEIGHT_W-1:0] rand_height();
    case ($urandom_range(0, 9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'sh0000;
      3, 4: return $signed(16'($urandom_range(0, 400))) - 16'sd200;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic push_random(input int cnt);
    for (int k = 0; k < cnt; k++) sample_q = {sample_q, rand_height()};
  endtask

  initial begin
    int unsigned sizes [5];
    logic signed [HEIGHT_W-1:0] corners [12];
    sizes = '{3, 5, 2, 9, 4};
    corners = '{
      16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF,
      16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000,
      16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000};
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_if.valid = 1'b0; in_if.height = '0; out_if.ready = 1'b0;
    err_cnt = 0; burst_left = 0; gap_left = 0; stall_mode = 0; stall_cnt = 0;
    sample_taken = 1'b0;
    grid_n = GRID_RESET; row_i = 0; col_j = 0;
    left_h = '0; above_left_h = '0;
    foreach (line_mem[k]) line_mem[k] = '0;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset grid size: one row plus a few quads
    push_random(GRID_RESET + 6);
    wait_idle();

    // smallest grid through the clamp: extreme and zero corner heights, grid wraps
    write_grid_size(0);
    foreach (corners[k]) sample_q = {sample_q, corners[k]};
    wait_idle();

    // largest grid through the clamp
    write_grid_size(2047);
    push_random(8);
    wait_idle();

    write_grid_size(1);
    push_random(12);
    wait_idle();

    foreach (sizes[s]) begin
      write_grid_size(sizes[s]);
      push_random(8);
      // hold off the next samples until every vertex has drained
      while (sample_q.size() > 0 || in_if.valid || vertex_q.size() > 0) @(posedge clk);
      push_random(8);
      wait_idle();
    end

    if (err_cnt == 0) begin
      $display("heightmap_mesh_flat_normals_core_tb OK");
    end else begin
      $display("heightmap_mesh_flat_normals_core_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("heightmap_mesh_flat_normals_core_tb NOT OK");
    $finish;
  end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/hmfn_pkg.sv
hw/rtl/hmfn_if.sv
hw/rtl/hmfn_ram.sv
hw/rtl/hmfn_posdiv.sv
hw/rtl/hmfn_normal.sv
hw/rtl/heightmap_mesh_flat_normals_core.sv
hw/rtl/hmfn_checker.sv
bench/heightmap_mesh_flat_normals_core_tb.sv
